// ===== hw/rtl/vlrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlrt_pkg: shared types and constants of the level/record trigger
// Sequencer states, register indexes, datapath widths and smoothing factors.
// ----------------------------------------------------------------------------
package vlrt_pkg;

   localparam int MAX_PACKET_LEN_DEF = 16384;
   localparam int SAMPLE_BITS_DEF    = 16;

   // datapath widths
   localparam int CNT_W   = 14;   // sample counter (threshold register width)
   localparam int N_W     = 15;   // packet length, up to 16384
   localparam int SUM_W   = 31;   // signed sample sum
   localparam int SQS_W   = 45;   // sum of squares
   localparam int MUL_W   = 60;   // serial multiplier product
   localparam int MB_W    = 31;   // serial multiplier shift-out operand
   localparam int ROOT_W  = 30;   // square root result
   localparam int QUO_W   = 51;   // gain * 32 * root / n
   localparam int LVL_W   = 17;   // Q1.16 level, 0..65536
   localparam int STEP_W  = 6;

   localparam int SQRT_STEPS = MUL_W / 2;
   localparam int DIV_STEPS  = QUO_W;

   localparam logic [LVL_W-1:0] LEVEL_ONE  = 17'h10000;
   localparam logic [15:0]      ATTACK_Q16 = 16'd63570;
   localparam logic [15:0]      DECAY_Q16  = 16'd45875;

   // configuration register indexes
   localparam logic [2:0] CSR_PACKET_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_GAIN             = 3'd1;
   localparam logic [2:0] CSR_STOP_LEVEL       = 3'd2;
   localparam logic [2:0] CSR_TRIGGER_LEVEL    = 3'd3;
   localparam logic [2:0] CSR_RETRIGGER_LEVEL  = 3'd4;
   localparam logic [2:0] CSR_MUTED            = 3'd5;
   localparam logic [2:0] CSR_STANDBY          = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_ACC,
      ST_NS2,
      ST_S1SQ,
      ST_ROOT1,
      ST_GAIN,
      ST_DIV,
      ST_ROOT2,
      ST_SMUL,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/vu_level_record_trigger.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vu_level_record_trigger: VU level meter with level-triggered recording
// Accumulates sample statistics per packet, forms a Q1.16 level from the
// fourth root of gain^2 * variance, smooths it and runs the record trigger.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+-------------------------
//  req     | req_sample, req_analysis_done           | req_valid & req_ready
//  rsp     | rsp_shown_level, rsp_recording,          | rsp_valid & rsp_ready
//          | rsp_started, rsp_ended                  |
//  csr     | csr_index, csr_wdata                    | csr_we
//
// Operation: the square of each sample is formed on one shared shift-add
// multiplier, one bit a cycle. The last sample of a packet adds n * S2, S1^2,
// two 30-step square roots, the gain product, a 51-step restoring divide and
// the smoothing product, all on the same serial multiplier / root / divide.
// Reset (synchronous) clears counters, sums, level and recording flags and
// loads the register defaults. A pending result in the output register does
// not stall sample intake; only the end of the next packet waits for it.
// ----------------------------------------------------------------------------
module vu_level_record_trigger #(
   parameter int MAX_PACKET_LEN = vlrt_pkg::MAX_PACKET_LEN_DEF,
   parameter int SAMPLE_BITS    = vlrt_pkg::SAMPLE_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   // sample channel
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample,
   input  wire                        req_analysis_done,
   // result channel
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [vlrt_pkg::LVL_W-1:0] rsp_shown_level,
   output logic                       rsp_recording,
   output logic                       rsp_started,
   output logic                       rsp_ended,
   // register writes
   input  wire                        csr_we,
   input  wire  [2:0]                 csr_index,
   input  wire  [16:0]                csr_wdata
);

   localparam int               CAP_I   = MAX_PACKET_LEN - 1;
   localparam logic [16:0]      THR_CAP = 17'(CAP_I);

   // ---------------------------------------------------------------- registers
   logic [vlrt_pkg::CNT_W-1:0] thr_ff;
   logic [15:0]                gain_ff;
   logic [vlrt_pkg::LVL_W-1:0] stop_ff, trig_ff, retrig_ff;
   logic                       muted_ff, standby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= 14'd2205;
         gain_ff    <= 16'd4096;
         stop_ff    <= 17'd6554;
         trig_ff    <= 17'd31457;
         retrig_ff  <= 17'd19661;
         muted_ff   <= 1'b0;
         standby_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            vlrt_pkg::CSR_PACKET_THRESHOLD: thr_ff     <= csr_wdata[13:0];
            vlrt_pkg::CSR_GAIN:             gain_ff    <= csr_wdata[15:0];
            vlrt_pkg::CSR_STOP_LEVEL:       stop_ff    <= csr_wdata;
            vlrt_pkg::CSR_TRIGGER_LEVEL:    trig_ff    <= csr_wdata;
            vlrt_pkg::CSR_RETRIGGER_LEVEL:  retrig_ff  <= csr_wdata;
            vlrt_pkg::CSR_MUTED:            muted_ff   <= csr_wdata[0];
            vlrt_pkg::CSR_STANDBY:          standby_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   vlrt_pkg::state_type state_ff, state_in;

   // architectural state
   logic signed [vlrt_pkg::SUM_W-1:0] ssum_ff, ssum_in;
   logic [vlrt_pkg::SQS_W-1:0]        qsum_ff, qsum_in;
   logic [vlrt_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [vlrt_pkg::LVL_W-1:0]        slide_ff, slide_in;
   logic                              rec_ff, rec_in;
   logic                              rearm_ff, rearm_in;
   logic                              wait_ff, wait_in;

   // shared serial multiplier: p += a while b shifts out, a shifts up
   logic [vlrt_pkg::MUL_W-1:0] mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [vlrt_pkg::MB_W-1:0]  mul_b_ff, mul_b_in;
   // shared square root, two radicand bits per step
   logic [vlrt_pkg::MUL_W-1:0]  sq_rad_ff, sq_rad_in;
   logic [32:0]                 sq_rem_ff, sq_rem_in;
   logic [vlrt_pkg::ROOT_W-1:0] sq_root_ff, sq_root_in;
   // restoring divider, one quotient bit per step
   logic [vlrt_pkg::QUO_W-1:0]  div_q_ff, div_q_in;
   logic [vlrt_pkg::CNT_W-1:0]  div_rem_ff, div_rem_in;
   // packet scratch
   logic [vlrt_pkg::N_W-1:0]    n_ff, n_in;
   logic [vlrt_pkg::MUL_W-1:0]  d_ff, d_in;
   logic [vlrt_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        attack_ff, attack_in;
   // result register
   logic                        rsp_valid_in;
   logic [vlrt_pkg::LVL_W-1:0]  rsp_level_in;
   logic                        rsp_rec_in, rsp_start_in, rsp_end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vlrt_pkg::ST_IDLE;
         ssum_ff   <= '0;
         qsum_ff   <= '0;
         cnt_ff    <= '0;
         slide_ff  <= '0;
         rec_ff    <= 1'b0;
         rearm_ff  <= 1'b1;
         wait_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ssum_ff   <= ssum_in;
         qsum_ff   <= qsum_in;
         cnt_ff    <= cnt_in;
         slide_ff  <= slide_in;
         rec_ff    <= rec_in;
         rearm_ff  <= rearm_in;
         wait_ff   <= wait_in;
         rsp_valid <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff        <= mul_a_in;
      mul_b_ff        <= mul_b_in;
      mul_p_ff        <= mul_p_in;
      sq_rad_ff       <= sq_rad_in;
      sq_rem_ff       <= sq_rem_in;
      sq_root_ff      <= sq_root_in;
      div_q_ff        <= div_q_in;
      div_rem_ff      <= div_rem_in;
      n_ff            <= n_in;
      d_ff            <= d_in;
      step_ff         <= step_in;
      attack_ff       <= attack_in;
      rsp_shown_level <= rsp_level_in;
      rsp_recording   <= rsp_rec_in;
      rsp_started     <= rsp_start_in;
      rsp_ended       <= rsp_end_in;
   end

   // ---------------------------------------------------------------- sample to Q1.15
   logic signed [15:0] q15;
   generate
      if (SAMPLE_BITS >= 16) begin : g_trunc
         assign q15 = req_sample[SAMPLE_BITS-1 -: 16];
      end else begin : g_pad
         assign q15 = {req_sample, {(16-SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   logic [15:0] q15_mag;
   assign q15_mag = q15[15] ? 16'(-q15) : q15;

   // ---------------------------------------------------------------- step logic
   logic                       mul_end;      // multiplier has consumed all bits
   logic [vlrt_pkg::MUL_W-1:0] mul_step_p;
   logic [32:0]                sq_t, sq_trial;
   logic                       sq_ge;
   logic [vlrt_pkg::ROOT_W-1:0] root_next;
   logic [vlrt_pkg::N_W-1:0]   div_t;
   logic                       div_ge;
   logic                       last_step;
   logic [vlrt_pkg::N_W-1:0]   n_next;
   logic [16:0]                thr_eff;
   logic                       pkt_done;
   logic [vlrt_pkg::SQS_W-1:0] qsum_new;
   logic [29:0]                s1_mag;
   logic [vlrt_pkg::LVL_W-1:0] lvl;
   logic [33:0]                adj_full;
   logic [vlrt_pkg::LVL_W-1:0] shown;

   assign mul_end    = (mul_b_ff == '0);
   assign mul_step_p = mul_p_ff + (mul_b_ff[0] ? mul_a_ff : '0);

   assign sq_t      = {sq_rem_ff[30:0], sq_rad_ff[vlrt_pkg::MUL_W-1 -: 2]};
   assign sq_trial  = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge     = (sq_t >= sq_trial);
   assign root_next = {sq_root_ff[vlrt_pkg::ROOT_W-2:0], sq_ge};

   assign div_t  = {div_rem_ff, div_q_ff[vlrt_pkg::QUO_W-1]};
   assign div_ge = (div_t >= n_ff);

   assign last_step = (step_ff == '0);

   // packet end when n exceeds the threshold (capped by the packet limit)
   assign thr_eff  = ({3'b0, thr_ff} > THR_CAP) ? THR_CAP : {3'b0, thr_ff};
   assign n_next   = {1'b0, cnt_ff} + 15'd1;
   assign pkt_done = ({2'b0, n_next} > thr_eff);
   assign qsum_new = qsum_ff + vlrt_pkg::SQS_W'(mul_p_ff[31:0]);

   assign s1_mag = ssum_ff[vlrt_pkg::SUM_W-1] ? 30'(-ssum_ff) : ssum_ff[29:0];

   assign lvl = (root_next > vlrt_pkg::ROOT_W'(vlrt_pkg::LEVEL_ONE))
                ? vlrt_pkg::LEVEL_ONE : root_next[vlrt_pkg::LVL_W-1:0];

   // rounded Q16 smoothing adjustment
   assign adj_full = mul_p_ff[33:0] + 34'd32768;

   assign shown = muted_ff ? '0 : slide_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vlrt_pkg::ST_IDLE:  if (req_valid) state_in = vlrt_pkg::ST_SQR;
         vlrt_pkg::ST_SQR:   if (mul_end) state_in = vlrt_pkg::ST_ACC;
         vlrt_pkg::ST_ACC:   state_in = pkt_done ? vlrt_pkg::ST_NS2 : vlrt_pkg::ST_IDLE;
         vlrt_pkg::ST_NS2:   if (mul_end) state_in = vlrt_pkg::ST_S1SQ;
         vlrt_pkg::ST_S1SQ:  if (mul_end) state_in = vlrt_pkg::ST_ROOT1;
         vlrt_pkg::ST_ROOT1: if (last_step) state_in = vlrt_pkg::ST_GAIN;
         vlrt_pkg::ST_GAIN:  if (mul_end) state_in = vlrt_pkg::ST_DIV;
         vlrt_pkg::ST_DIV:   if (last_step) state_in = vlrt_pkg::ST_ROOT2;
         vlrt_pkg::ST_ROOT2: if (last_step) state_in = vlrt_pkg::ST_SMUL;
         vlrt_pkg::ST_SMUL:  if (mul_end) state_in = vlrt_pkg::ST_DONE;
         vlrt_pkg::ST_DONE:  if (!rsp_valid || rsp_ready) state_in = vlrt_pkg::ST_IDLE;
         default:            state_in = vlrt_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   logic mul_run, sq_run, div_run;

   always_comb begin
      req_ready = 1'b0;
      mul_run   = 1'b0;
      sq_run    = 1'b0;
      div_run   = 1'b0;
      case (state_ff)
         vlrt_pkg::ST_IDLE:  req_ready = 1'b1;
         vlrt_pkg::ST_SQR,
         vlrt_pkg::ST_NS2,
         vlrt_pkg::ST_S1SQ,
         vlrt_pkg::ST_GAIN,
         vlrt_pkg::ST_SMUL:  mul_run = !mul_end;
         vlrt_pkg::ST_ROOT1,
         vlrt_pkg::ST_ROOT2: sq_run = 1'b1;
         vlrt_pkg::ST_DIV:   div_run = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      ssum_in      = ssum_ff;
      qsum_in      = qsum_ff;
      cnt_in       = cnt_ff;
      slide_in     = slide_ff;
      rec_in       = rec_ff;
      rearm_in     = rearm_ff;
      wait_in      = wait_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_p_in     = mul_p_ff;
      sq_rad_in    = sq_rad_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      step_in      = step_ff;
      attack_in    = attack_ff;
      rsp_valid_in = rsp_valid && !rsp_ready;
      rsp_level_in = rsp_shown_level;
      rsp_rec_in   = rsp_recording;
      rsp_start_in = rsp_started;
      rsp_end_in   = rsp_ended;

      // shared units step
      if (mul_run) begin
         mul_p_in = mul_step_p;
         mul_a_in = {mul_a_ff[vlrt_pkg::MUL_W-2:0], 1'b0};
         mul_b_in = {1'b0, mul_b_ff[vlrt_pkg::MB_W-1:1]};
      end
      if (sq_run) begin
         sq_rem_in  = sq_ge ? (sq_t - sq_trial) : sq_t;
         sq_root_in = root_next;
         sq_rad_in  = {sq_rad_ff[vlrt_pkg::MUL_W-3:0], 2'b00};
         step_in    = step_ff - 6'd1;
      end
      if (div_run) begin
         div_rem_in = div_ge ? 14'(div_t - n_ff) : div_t[vlrt_pkg::CNT_W-1:0];
         div_q_in   = {div_q_ff[vlrt_pkg::QUO_W-2:0], div_ge};
         step_in    = step_ff - 6'd1;
      end

      case (state_ff)
         vlrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_analysis_done) wait_in = 1'b0;
               ssum_in  = ssum_ff + vlrt_pkg::SUM_W'(q15);
               mul_a_in = vlrt_pkg::MUL_W'(q15_mag);
               mul_b_in = vlrt_pkg::MB_W'(q15_mag);
               mul_p_in = '0;
            end
         end
         vlrt_pkg::ST_ACC: begin
            if (pkt_done) begin
               // n * S2 with the sums cleared for the next packet
               qsum_in  = '0;
               cnt_in   = '0;
               n_in     = n_next;
               mul_a_in = vlrt_pkg::MUL_W'(qsum_new);
               mul_b_in = vlrt_pkg::MB_W'(n_next);
               mul_p_in = '0;
            end else begin
               qsum_in = qsum_new;
               cnt_in  = n_next[vlrt_pkg::CNT_W-1:0];
            end
         end
         vlrt_pkg::ST_NS2: begin
            if (mul_end) begin
               d_in     = mul_p_ff;
               ssum_in  = '0;
               mul_a_in = vlrt_pkg::MUL_W'(s1_mag);
               mul_b_in = vlrt_pkg::MB_W'(s1_mag);
               mul_p_in = '0;
            end
         end
         vlrt_pkg::ST_S1SQ: begin
            if (mul_end) begin
               // D = n*S2 - S1^2, floored at zero
               sq_rad_in  = (d_ff > mul_p_ff) ? (d_ff - mul_p_ff) : '0;
               sq_rem_in  = '0;
               sq_root_in = '0;
               step_in    = 6'(vlrt_pkg::SQRT_STEPS - 1);
            end
         end
         vlrt_pkg::ST_ROOT1: begin
            if (last_step) begin
               mul_a_in = {25'b0, root_next, 5'b0};
               mul_b_in = vlrt_pkg::MB_W'(gain_ff);
               mul_p_in = '0;
            end
         end
         vlrt_pkg::ST_GAIN: begin
            if (mul_end) begin
               div_q_in   = mul_p_ff[vlrt_pkg::QUO_W-1:0];
               div_rem_in = '0;
               step_in    = 6'(vlrt_pkg::DIV_STEPS - 1);
            end
         end
         vlrt_pkg::ST_DIV: begin
            if (last_step) begin
               sq_rad_in  = vlrt_pkg::MUL_W'({div_q_ff[vlrt_pkg::QUO_W-2:0], div_ge});
               sq_rem_in  = '0;
               sq_root_in = '0;
               step_in    = 6'(vlrt_pkg::SQRT_STEPS - 1);
            end
         end
         vlrt_pkg::ST_ROOT2: begin
            if (last_step) begin
               attack_in = (lvl > slide_ff);
               mul_a_in  = vlrt_pkg::MUL_W'((lvl > slide_ff) ? (lvl - slide_ff)
                                                             : (slide_ff - lvl));
               mul_b_in  = vlrt_pkg::MB_W'((lvl > slide_ff) ? vlrt_pkg::ATTACK_Q16
                                                            : vlrt_pkg::DECAY_Q16);
               mul_p_in  = '0;
            end
         end
         vlrt_pkg::ST_SMUL: begin
            if (mul_end) begin
               slide_in = attack_ff ? (slide_ff + adj_full[32:16])
                                    : (slide_ff - adj_full[32:16]);
            end
         end
         vlrt_pkg::ST_DONE: begin
            if (!rsp_valid || rsp_ready) begin
               rsp_start_in = 1'b0;
               rsp_end_in   = 1'b0;
               // end check first, then rearm and start unless blocked
               if (rec_ff && (shown < stop_ff)) begin
                  rec_in     = 1'b0;
                  rearm_in   = 1'b1;
                  rsp_end_in = 1'b1;
               end
               if (!standby_ff && !wait_ff) begin
                  if (!rearm_in && (slide_ff < retrig_ff)) rearm_in = 1'b1;
                  if ((shown > trig_ff) && rearm_in) begin
                     rec_in       = 1'b1;
                     rearm_in     = 1'b0;
                     wait_in      = 1'b1;
                     rsp_start_in = 1'b1;
                  end
               end
               rsp_rec_in   = rec_in;
               rsp_level_in = shown;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/vlrt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlrt_checker: port-level checks for the level/record trigger
// Watches the result channel for consistent flags and a held payload.
// ----------------------------------------------------------------------------
module vlrt_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [16:0] rsp_shown_level,
   input wire        rsp_recording,
   input wire        rsp_started,
   input wire        rsp_ended
);

   // a start always leaves the recorder running
   a_start_rec : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_started |-> rsp_recording)
      else $error("started without recording");

   // an end without a restart leaves it stopped
   a_end_stop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ended && !rsp_started |-> !rsp_recording)
      else $error("ended but still recording");

   a_level_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_level <= 17'h10000)
      else $error("shown level above one");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shown_level)
                                   && $stable(rsp_recording))
      else $error("stalled result changed");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind vu_level_record_trigger vlrt_checker u_vlrt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_shown_level (rsp_shown_level),
   .rsp_recording   (rsp_recording),
   .rsp_started     (rsp_started),
   .rsp_ended       (rsp_ended)
);
`default_nettype wire

// ===== tb/sv/vu_level_record_trigger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vu_level_record_trigger_tb: self-checking bench for the level/record trigger
// Drives audio samples over the req channel with random gaps and drains
// packet results over the rsp channel with random stalls. Each result is
// checked field by field against a packet-level predictor of the block.
// ----------------------------------------------------------------------------
module vu_level_record_trigger_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 400;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               analysis_done;
   } sample_item_type;

   typedef struct packed {
      logic [vlrt_pkg::LVL_W-1:0] shown_level;
      logic                       recording;
      logic                       started;
      logic                       ended;
   } level_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = '0;
   logic               req_analysis_done = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [vlrt_pkg::LVL_W-1:0] rsp_shown_level;
   logic               rsp_recording, rsp_started, rsp_ended;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [16:0]        csr_wdata = '0;

   vu_level_record_trigger uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_analysis_done(req_analysis_done),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_shown_level(rsp_shown_level), .rsp_recording(rsp_recording),
      .rsp_started(rsp_started), .rsp_ended(rsp_ended),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: shadow registers plus packet statistics
   // ---------------------------------------------------------------------
   logic [13:0]        p_thresh;
   logic [15:0]        p_gain;
   logic [16:0]        p_stop, p_trig, p_retrig;
   logic               p_muted, p_standby;
   logic signed [63:0] acc_sum;
   logic [63:0]        acc_sq;
   logic [63:0]        acc_cnt;
   logic [16:0]        slide;
   logic               rec_on, rearmed, wait_ack;

   sample_item_type   pending_samples[$];
   level_result_type  expected_levels[$];
   int             errors = 0;
   bit             sender_hold = 1'b0;   // pause driver (pressure/config)
   bit             rx_long_hold = 1'b0;  // long receiver stall request

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic shadow_reset();
      p_thresh = 14'd2205; p_gain = 16'd4096; p_stop = 17'd6554;
      p_trig = 17'd31457; p_retrig = 17'd19661; p_muted = 0; p_standby = 0;
      acc_sum = 0; acc_sq = 0; acc_cnt = 0; slide = 0;
      rec_on = 0; rearmed = 1; wait_ack = 0;
   endtask

   // Runs one accepted sample through the predictor; may queue a result.
   task automatic predict_level(input sample_item_type it);
      logic signed [63:0] s;
      logic [63:0] n, mag, prod, d, x, lvl, thr;
      logic [16:0] shown;
      level_result_type r;
      if (it.analysis_done) wait_ack = 0;
      s = it.sample;
      acc_sum += s;
      acc_sq  += s * s;
      thr = p_thresh;
      n = acc_cnt + 1;
      if (n <= thr) begin
         acc_cnt = n;
      end else begin
         mag = (acc_sum < 0) ? -acc_sum : acc_sum;
         prod = n * acc_sq;
         d = (prod > mag * mag) ? prod - mag * mag : 0;
         acc_sum = 0; acc_sq = 0; acc_cnt = 0;
         x = (64'(p_gain) * 32 * floor_sqrt(d)) / n;
         lvl = floor_sqrt(x);
         if (lvl > 65536) lvl = 65536;
         // attack / decay smoothing, rounded half up
         if (lvl > slide)
            slide = slide + 17'(((lvl - slide) * vlrt_pkg::ATTACK_Q16 + 32768) >> 16);
         else
            slide = slide - 17'(((slide - lvl) * vlrt_pkg::DECAY_Q16 + 32768) >> 16);
         shown = p_muted ? 17'd0 : slide;
         r = '0;
         // end check first; start may follow in the same packet
         if (rec_on && shown < p_stop) begin
            rec_on = 0; rearmed = 1; r.ended = 1;
         end
         if (!p_standby && !wait_ack) begin
            if (!rearmed && slide < p_retrig) rearmed = 1;
            if (shown > p_trig && rearmed) begin
               rec_on = 1; rearmed = 0; wait_ack = 1; r.started = 1;
            end
         end
         r.shown_level = shown;
         r.recording = rec_on;
         expected_levels = {expected_levels, r};
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: one transfer per pending item, random gap before each
   // ---------------------------------------------------------------------
   int tx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         predict_level({req_sample, req_analysis_done});
         req_valid <= 1'b0;
         tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      end else if (!req_valid && !sender_hold) begin
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (pending_samples.size() > 0) begin
            sample_item_type it;
            it = pending_samples.pop_front();
            req_sample <= it.sample;
            req_analysis_done <= it.analysis_done;
            req_valid <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor / receiver: random stalls, long stall on request
   // ---------------------------------------------------------------------
   int rx_wait = 0;
   int rx_long_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               level_result_type e;
               e = expected_levels.pop_front();
               if (rsp_shown_level !== e.shown_level)
                  report_mismatch("shown_level", rsp_shown_level, e.shown_level);
               if (rsp_recording !== e.recording)
                  report_mismatch("recording", rsp_recording, e.recording);
               if (rsp_started !== e.started)
                  report_mismatch("started", rsp_started, e.started);
               if (rsp_ended !== e.ended)
                  report_mismatch("ended", rsp_ended, e.ended);
            end
            rx_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
         end
         if (rx_long_hold && rx_long_cnt < 3000) begin
            rx_long_cnt++;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: cycles with no transfer on either channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[vu_level_record_trigger] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_sample(input int v, input bit ad);
      sample_item_type it;
      it.sample = 16'(v);
      it.analysis_done = ad;
      pending_samples = {pending_samples, it};
   endtask

   // Loud or quiet packet of len samples; occasionally acknowledges.
   task automatic push_packet(input int len, input int amp);
      for (int i = 0; i < len; i++)
         push_sample($signed(16'($urandom_range(0, 2 * amp))) - amp,
                     $urandom_range(0, 5) == 0);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_levels.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_we is cleared and held low before the task returns, so the enable is never set and cleared together
   task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         vlrt_pkg::CSR_PACKET_THRESHOLD: p_thresh = val[13:0];
         vlrt_pkg::CSR_GAIN:             p_gain = val[15:0];
         vlrt_pkg::CSR_STOP_LEVEL:       p_stop = val;
         vlrt_pkg::CSR_TRIGGER_LEVEL:    p_trig = val;
         vlrt_pkg::CSR_RETRIGGER_LEVEL:  p_retrig = val;
         vlrt_pkg::CSR_MUTED:            p_muted = val[0];
         vlrt_pkg::CSR_STANDBY:          p_standby = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin
      int plen;
      shadow_reset();
      sender_hold = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero threshold (a result per sample), extremes, zero gain
      write_reg(vlrt_pkg::CSR_PACKET_THRESHOLD, 17'd0);
      write_reg(vlrt_pkg::CSR_GAIN, 17'd65535);
      write_reg(vlrt_pkg::CSR_STOP_LEVEL, 17'd0);
      write_reg(vlrt_pkg::CSR_TRIGGER_LEVEL, 17'd0);
      write_reg(vlrt_pkg::CSR_RETRIGGER_LEVEL, 17'd65536);
      write_reg(vlrt_pkg::CSR_MUTED, 17'd0);
      write_reg(vlrt_pkg::CSR_STANDBY, 17'd0);
      sender_hold = 1'b0;
      push_sample(-32768, 0); push_sample(32767, 1); push_sample(0, 0);
      push_sample(-1, 1); push_sample(1, 0);
      wait_drained();
      sender_hold = 1'b1;
      write_reg(vlrt_pkg::CSR_PACKET_THRESHOLD, 17'd1);
      sender_hold = 1'b0;
      // full swing: level clips at one and triggers; a zero stop level allows no end
      push_sample(32767, 0); push_sample(-32768, 0);
      push_sample(32767, 1); push_sample(-32768, 0);
      push_sample(0, 1); push_sample(0, 0);
      push_sample(-32768, 0); push_sample(-32768, 1);
      wait_drained();
      sender_hold = 1'b1;
      write_reg(vlrt_pkg::CSR_GAIN, 17'd0);
      write_reg(vlrt_pkg::CSR_MUTED, 17'd1);
      write_reg(vlrt_pkg::CSR_STANDBY, 17'd1);
      sender_hold = 1'b0;
      push_sample(32767, 0); push_sample(-32768, 1);
      push_sample(12345, 0); push_sample(-4321, 0);
      wait_drained();

      // Random phases with varied register settings
      for (int ph = 0; ph < 12; ph++) begin
         sender_hold = 1'b1;
         plen = (ph == 11) ? 450 : $urandom_range(1, 12);
         write_reg(vlrt_pkg::CSR_PACKET_THRESHOLD, 17'(plen - 1));
         write_reg(vlrt_pkg::CSR_GAIN, ph == 0 ? 17'd1 : ph == 1 ? 17'd65535
                              : 17'($urandom_range(1, 65535)));
         write_reg(vlrt_pkg::CSR_STOP_LEVEL,
                   ph == 2 ? 17'd65536 : 17'($urandom_range(0, 30000)));
         write_reg(vlrt_pkg::CSR_TRIGGER_LEVEL,
                   ph == 3 ? 17'd65536 : 17'($urandom_range(0, 65536)));
         write_reg(vlrt_pkg::CSR_RETRIGGER_LEVEL,
                   ph == 4 ? 17'd0 : 17'($urandom_range(0, 65536)));
         write_reg(vlrt_pkg::CSR_MUTED, 17'($urandom_range(0, 5) == 0));
         write_reg(vlrt_pkg::CSR_STANDBY, 17'($urandom_range(0, 5) == 0));
         sender_hold = 1'b0;
         if (ph == 11) begin
            // one long full-swing packet
            push_packet(plen, 32767);
         end else begin
            if (ph == 5) rx_long_hold = 1'b1;  // receiver stall; intake backs up
            for (int k = 0; k < 40 / plen + 3; k++)
               push_packet(plen, $urandom_range(0, 3) == 0 ? 200 : 32767);
         end
         wait_drained();
         rx_long_hold = 1'b0;
      end

      if (errors == 0)
         $display("[vu_level_record_trigger] OK");
      else
         $display("[vu_level_record_trigger] ERROR");
      $finish;
   end

endmodule
